// ----- src/sle_pkg.sv -----
// shared types, widths and codes for the sprite line evaluation block
// used by every module under src; depends on nothing else
package sle_pkg;

    localparam int CMD_W   = 3;
    localparam int DOT_W   = 9;
    localparam int LINE_W  = 10;
    localparam int BYTE_W  = 8;
    localparam int SIDX_W  = 5;
    localparam int PH_W    = 3;
    localparam int PTR_W   = 8;
    localparam int SPTR_W  = 5;
    localparam int PRIMARY_BYTES   = 256;
    localparam int SECONDARY_BYTES = 32;
    localparam int SPRITE_HEIGHT   = 8;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PTR     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLR_OVF = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SREAD   = 3'd4;

    // evaluation phase codes
    localparam logic [PH_W-1:0] PH_COPY_Y    = 3'd0;
    localparam logic [PH_W-1:0] PH_COPY_REST = 3'd1;
    localparam logic [PH_W-1:0] PH_OVF_SCAN  = 3'd2;
    localparam logic [PH_W-1:0] PH_OVF_REST  = 3'd3;
    localparam logic [PH_W-1:0] PH_WAIT      = 3'd4;

    localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DOT_W-1:0]  dot;
        logic [LINE_W-1:0] line;
        logic              render_enable;
        logic [BYTE_W-1:0] write_byte;
        logic [SIDX_W-1:0] secondary_index;
    } item_t;

    typedef struct packed {
        logic              wr_en;
        logic [PTR_W-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [PTR_W-1:0]  rd_addr;
    } ptab_req_t;

    typedef struct packed {
        logic              en;
        logic [SPTR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } stab_wr_t;

    typedef struct packed {
        logic            overflow;
        logic [PH_W-1:0] phase;
    } stat_t;

endpackage

// ----- src/sle_ptable.sv -----
// primary sprite table: 256-byte memory, one write and one registered read per cycle
// per-entry valid bits give the all-zero reset; keeps a copy of byte 0
// depends on sle_pkg
module sle_ptable (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sle_pkg::ptab_req_t        req,
    output logic [sle_pkg::BYTE_W-1:0] rd_data,
    output logic [sle_pkg::BYTE_W-1:0] byte0
);
    import sle_pkg::*;

    logic [BYTE_W-1:0]        mem_reg [PRIMARY_BYTES];
    logic [PRIMARY_BYTES-1:0] valid_reg;
    logic [BYTE_W-1:0]        rd_raw_reg;
    logic                     rd_vld_reg;
    logic [BYTE_W-1:0]        byte0_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_raw_reg <= mem_reg[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
            byte0_reg  <= '0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
                if (req.wr_addr == '0)
                begin
                    byte0_reg <= req.wr_data;
                end
            end
            // read and write never hit the same entry in one cycle
            if (req.rd_en)
            begin
                rd_vld_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_raw_reg : '0;
    assign byte0   = byte0_reg;

endmodule

// ----- src/sle_stable.sv -----
// secondary sprite table: 32 bytes in flops, one write port and one read port
// depends on sle_pkg
module sle_stable (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sle_pkg::stab_wr_t           wr,
    input  logic [sle_pkg::SIDX_W-1:0]  rd_addr,
    output logic [sle_pkg::BYTE_W-1:0]  rd_data
);
    import sle_pkg::*;

    logic [BYTE_W-1:0] tab_reg [SECONDARY_BYTES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SECONDARY_BYTES; i++)
            begin
                tab_reg[i] <= FILL_BYTE;
            end
        end
        else if (wr.en)
        begin
            tab_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data = tab_reg[rd_addr];

endmodule

// ----- src/sle_eval.sv -----
// evaluation state and next-state logic: pointers, fetched y byte, phase, overflow
// drives the write and read ports of the primary table and the write port of the secondary table; depends on sle_pkg
module sle_eval (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  sle_pkg::item_t              item,
    input  logic [sle_pkg::BYTE_W-1:0]  cur_byte,
    input  logic [sle_pkg::BYTE_W-1:0]  byte0,
    output sle_pkg::ptab_req_t          ptab_req,
    output sle_pkg::stab_wr_t           stab_wr,
    output sle_pkg::stat_t              stat_next,
    output sle_pkg::stat_t              stat
);
    import sle_pkg::*;

    logic [PTR_W-1:0]  tp_reg, tp_next;
    logic [SPTR_W-1:0] sp_reg, sp_next;
    logic [BYTE_W-1:0] fb_reg, fb_next;
    logic [PH_W-1:0]   ph_reg, ph_next;
    logic              ovf_reg, ovf_next;

    logic [PTR_W-1:0]  tp_base;
    logic [SPTR_W-1:0] sp_base;
    logic [PH_W-1:0]   ph_base;
    logic [PTR_W-1:0]  tp_p1, tp_p4, tp_skew;
    logic [SPTR_W-1:0] sp_p1;
    logic [DOT_W-1:0]  dot_m1;
    logic              is_dot65;
    logic              in_rng;
    logic signed [LINE_W+1:0] target;
    logic signed [LINE_W+1:0] y_lo;
    logic signed [LINE_W+1:0] y_hi;

    // sprite covers the next line when y <= line+1 < y+8
    assign target = {{2{item.line[LINE_W-1]}}, item.line} + 12'sd1;
    assign y_lo   = $signed({4'b0, fb_reg});
    assign y_hi   = y_lo + 12'sd8;
    assign in_rng = (target >= y_lo) && (target < y_hi);

    assign is_dot65 = (item.dot == 9'd65);
    assign dot_m1   = item.dot - 9'd1;

    always_comb
    begin
        tp_base = is_dot65 ? '0 : tp_reg;
        sp_base = is_dot65 ? '0 : sp_reg;
        ph_base = is_dot65 ? PH_COPY_Y : ph_reg;
        tp_p1   = tp_base + 8'd1;
        tp_p4   = tp_base + 8'h04;
        sp_p1   = sp_base + 5'd1;
        tp_skew = tp_base + ((tp_base[1:0] == 2'b11) ? 8'd1 : 8'd5);
    end

    always_comb
    begin
        tp_next  = tp_reg;
        sp_next  = sp_reg;
        fb_next  = fb_reg;
        ph_next  = ph_reg;
        ovf_next = ovf_reg;
        stab_wr  = '0;
        ptab_req = '0;
        unique case (item.cmd)
            CMD_TICK:
            begin
                if (item.render_enable)
                begin
                    if ((item.dot >= 9'd1) && (item.dot <= 9'd64))
                    begin
                        if (!item.dot[0])
                        begin
                            stab_wr.en   = 1'b1;
                            stab_wr.addr = dot_m1[5:1];
                            stab_wr.data = FILL_BYTE;
                        end
                    end
                    else if ((item.dot >= 9'd65) && (item.dot <= 9'd256))
                    begin
                        tp_next = tp_base;
                        sp_next = sp_base;
                        ph_next = ph_base;
                        if (item.dot[0])
                        begin
                            // odd dot: fetch the byte under the pointer
                            fb_next = is_dot65 ? byte0 : cur_byte;
                        end
                        else
                        begin
                            unique case (ph_base)
                                PH_COPY_Y:
                                begin
                                    stab_wr.en   = 1'b1;
                                    stab_wr.addr = sp_base;
                                    stab_wr.data = fb_reg;
                                    if (in_rng)
                                    begin
                                        ph_next = PH_COPY_REST;
                                        sp_next = sp_p1;
                                        tp_next = tp_p1;
                                    end
                                    else
                                    begin
                                        tp_next = tp_p4;
                                        if (tp_p4 == '0)
                                        begin
                                            ph_next = PH_WAIT;
                                        end
                                    end
                                end
                                PH_COPY_REST:
                                begin
                                    stab_wr.en   = 1'b1;
                                    stab_wr.addr = sp_base;
                                    stab_wr.data = fb_reg;
                                    sp_next = sp_p1;
                                    tp_next = tp_p1;
                                    if (sp_p1[1:0] == 2'b00)
                                    begin
                                        priority if (tp_p1 == '0)
                                        begin
                                            ph_next = PH_WAIT;
                                        end
                                        else if (sp_p1 == '0)
                                        begin
                                            ph_next = PH_OVF_SCAN;
                                        end
                                        else
                                        begin
                                            ph_next = PH_COPY_Y;
                                        end
                                    end
                                end
                                PH_OVF_SCAN:
                                begin
                                    if (in_rng)
                                    begin
                                        ovf_next = 1'b1;
                                        sp_next  = sp_p1;
                                        tp_next  = tp_p1;
                                        ph_next  = PH_OVF_REST;
                                    end
                                    else
                                    begin
                                        // skewed step: +1 at the end of a sprite, else +5
                                        tp_next = tp_skew;
                                        ph_next = (tp_skew[7:2] != '0) ? PH_OVF_SCAN : PH_WAIT;
                                    end
                                end
                                PH_OVF_REST:
                                begin
                                    tp_next = tp_p1;
                                    if (tp_p1[1:0] == 2'b00)
                                    begin
                                        ph_next = PH_WAIT;
                                    end
                                end
                                PH_WAIT:
                                begin
                                    tp_next = tp_p4;
                                end
                                default:
                                begin
                                    ph_next = PH_COPY_Y;
                                end
                            endcase
                        end
                    end
                end
            end
            CMD_WRITE:
            begin
                ptab_req.wr_en   = 1'b1;
                ptab_req.wr_addr = tp_reg;
                ptab_req.wr_data = item.write_byte;
                tp_next          = tp_reg + 8'd1;
            end
            CMD_PTR:
            begin
                tp_next = item.write_byte;
            end
            CMD_CLR_OVF:
            begin
                ovf_next = 1'b0;
            end
            default:
            begin
                // secondary reads and unused codes leave the state alone
            end
        endcase
        ptab_req.wr_en = ptab_req.wr_en & advance;
        stab_wr.en     = stab_wr.en & advance;
        ptab_req.rd_en   = advance;
        ptab_req.rd_addr = tp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_reg  <= '0;
            sp_reg  <= '0;
            fb_reg  <= '0;
            ph_reg  <= PH_COPY_Y;
            ovf_reg <= 1'b0;
        end
        else if (advance)
        begin
            tp_reg  <= tp_next;
            sp_reg  <= sp_next;
            fb_reg  <= fb_next;
            ph_reg  <= ph_next;
            ovf_reg <= ovf_next;
        end
    end

    assign stat_next.overflow = ovf_next;
    assign stat_next.phase    = ph_next;
    assign stat.overflow      = ovf_reg;
    assign stat.phase         = ph_reg;

endmodule

// ----- src/sprite_line_evaluation.sv -----
// sprite line evaluation top level: input register, evaluation, tables, result register
// depends on sle_pkg, sle_eval, sle_ptable, sle_stable
//
// usage
// one command beat in on the s_axis channel (kind in tuser, operands in tdata), one
// result beat out on the m_axis channel for every command, in order
// commands: dot tick, primary table write with pointer increment, pointer load,
// overflow clear, secondary table read
// a beat is registered on entry, then the evaluation logic updates the state and
// issues the primary table read together; that read data register is the primary
// byte of the result; results pass the input register, then the result register
// throughput is one beat per cycle while the receiver accepts results: the state
// update and the one-read-one-write primary table port set it
// when the receiver stalls, the result register holds and the input register
// fills; tready drops only while both are full
// reset clears the pointers, phase and overflow flag, marks every primary entry
// as zero through per-entry valid bits and fills the secondary table with 0xff;
// beats are accepted right after reset
module sprite_line_evaluation (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // dot[8:0], line[18:9], render_enable[19], write_byte[27:20],
    // secondary_index[32:28], zero fill
    input  logic [sle_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // cmd[2:0]
    input  logic [sle_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // primary_read_byte[7:0], secondary_read_byte[15:8], overflow[16], phase[19:17],
    // zero fill
    output logic [sle_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import sle_pkg::*;

    logic              in_valid_reg;
    item_t             in_item_reg;
    item_t             in_item;
    logic              accept;
    logic              advance;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_sread_reg;
    stat_t             out_stat_reg;
    logic [BYTE_W-1:0] sread;
    logic [BYTE_W-1:0] stab_rd_data;
    logic [BYTE_W-1:0] ptab_rd_data;
    logic [BYTE_W-1:0] ptab_byte0;
    ptab_req_t         ptab_req;
    stab_wr_t          stab_wr;
    stat_t             stat_next;
    stat_t             stat;

    assign in_item.cmd             = s_axis_tuser;
    assign in_item.dot             = s_axis_tdata[8:0];
    assign in_item.line            = s_axis_tdata[18:9];
    assign in_item.render_enable   = s_axis_tdata[19];
    assign in_item.write_byte      = s_axis_tdata[27:20];
    assign in_item.secondary_index = s_axis_tdata[32:28];

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_sread_reg <= sread;
            out_stat_reg  <= stat_next;
        end
    end

    sle_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (in_item_reg),
        .cur_byte  (ptab_rd_data),
        .byte0     (ptab_byte0),
        .ptab_req  (ptab_req),
        .stab_wr   (stab_wr),
        .stat_next (stat_next),
        .stat      (stat)
    );

    sle_ptable u_ptable (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ptab_req),
        .rd_data (ptab_rd_data),
        .byte0   (ptab_byte0)
    );

    sle_stable u_stable (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (stab_wr),
        .rd_addr (in_item_reg.secondary_index),
        .rd_data (stab_rd_data)
    );

    assign sread = (in_item_reg.cmd == CMD_SREAD) ? stab_rd_data : '0;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_stat_reg.phase, out_stat_reg.overflow,
                            out_sread_reg, ptab_rd_data};

    // an empty input register never blocks the slave side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input register empty but tready low");

    // the overflow flag is only raised by the scan stepping into the rest phase
    a_ovf_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stat.overflow) |-> (stat.phase == PH_OVF_REST))
        else $error("overflow set outside the overflow scan");

    // the result register takes every processed beat: no result is dropped
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register overwritten while stalled");

    // a state change only happens on a processed beat
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(stat))
        else $error("evaluation state moved without a beat");

endmodule
